FILE: src/iso_project_dda_line_assert.svh
// assertion macros used by the checker file
`ifndef ISO_PROJECT_DDA_LINE_ASSERT_SVH
`define ISO_PROJECT_DDA_LINE_ASSERT_SVH

// property checked on every rising edge outside reset
`define IDL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("idl assertion failed");

// property checked on every rising edge, reset included
`define IDL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("idl assertion failed");

`endif

FILE: src/idl_pkg.sv
`default_nettype none
package idl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_PIXELS = 64;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int POS_W      = 38;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int IT_W       = $clog2(FRAC_BITS + 1);
    localparam int PIX_W      = 18;
    localparam int Q_DEPTH    = 2;

    // cos(0.8) and sin(0.8) rounded to FRAC_BITS
    localparam logic [15:0] COS_F = 16'd45659;
    localparam logic [15:0] SIN_F = 16'd47013;

    localparam logic [23:0] COLOR_RAISED = 24'hff4242;
    localparam logic [23:0] COLOR_SUNKEN = 24'h4242ff;
    localparam logic [23:0] COLOR_FLAT   = 24'hffffff;

    typedef enum logic [1:0] {
        REG_ZOOM   = 2'd0,
        REG_HSCALE = 2'd1,
        REG_OFFX   = 2'd2,
        REG_OFFY   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        [6:0]  zoom;
        logic signed [5:0]  hscale;
        logic        [11:0] offx;
        logic        [11:0] offy;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] y0;
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic        [23:0]      color;
    } t_seg;

    function automatic logic far(input logic signed [POS_W-1:0] d);
        logic signed [POS_W-1:0] one;
        one = POS_W'(1) <<< FRAC_BITS;
        return (d >= one) || (d <= -one);
    endfunction

    function automatic logic [PIX_W-1:0] trunc_pix(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] ip;
        ip = v >>> FRAC_BITS;
        if (v[POS_W-1] && (|v[FRAC_BITS-1:0])) begin
            ip = ip + POS_W'(1);
        end
        return ip[PIX_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/idl_front.sv
`default_nettype none
module idl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire idl_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [63:0]   i_data,
    output logic               o_push,
    output idl_pkg::t_seg      o_seg,
    input  wire logic          i_full
);
    import idl_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_SUM} t_fstate;
    t_fstate r_state;

    logic        [9:0]  r_c0, r_r0, r_c1, r_r1;
    logic signed [10:0] r_h0, r_h1;
    logic        [16:0] r_p0, r_q0, r_p1, r_q1;
    logic signed [17:0] r_hh0, r_hh1;
    logic signed [34:0] r_xm0, r_xm1;
    logic signed [35:0] r_ym0, r_ym1;
    logic        [23:0] r_color;

    logic signed [10:0] h0_in, h1_in;
    logic        [23:0] color_in;
    logic signed [17:0] d0, d1;
    logic        [17:0] s0, s1;

    assign h0_in = $signed(i_data[50:40]);
    assign h1_in = $signed(i_data[61:51]);

    always_comb begin
        if ((!h0_in[10] && (|h0_in)) || (!h1_in[10] && (|h1_in))) begin
            color_in = COLOR_RAISED;
        end else if (h0_in[10] || h1_in[10]) begin
            color_in = COLOR_SUNKEN;
        end else begin
            color_in = COLOR_FLAT;
        end
    end

    assign d0 = $signed({1'b0, r_p0}) - $signed({1'b0, r_q0});
    assign d1 = $signed({1'b0, r_p1}) - $signed({1'b0, r_q1});
    assign s0 = {1'b0, r_p0} + {1'b0, r_q0};
    assign s1 = {1'b0, r_p1} + {1'b0, r_q1};

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_SUM) && !i_full;

    always_comb begin
        o_seg.x0 = POS_W'(r_xm0) + (POS_W'(i_cfg.offx) <<< FRAC_BITS);
        o_seg.x1 = POS_W'(r_xm1) + (POS_W'(i_cfg.offx) <<< FRAC_BITS);
        o_seg.y0 = POS_W'(r_ym0) - (POS_W'(r_hh0) <<< FRAC_BITS)
                 + (POS_W'(i_cfg.offy) <<< FRAC_BITS);
        o_seg.y1 = POS_W'(r_ym1) - (POS_W'(r_hh1) <<< FRAC_BITS)
                 + (POS_W'(i_cfg.offy) <<< FRAC_BITS);
        o_seg.color = r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_c0    <= i_data[9:0];
                        r_r0    <= i_data[19:10];
                        r_c1    <= i_data[29:20];
                        r_r1    <= i_data[39:30];
                        r_h0    <= h0_in;
                        r_h1    <= h1_in;
                        r_color <= color_in;
                        r_state <= F_MUL1;
                    end
                end
                F_MUL1: begin
                    r_p0    <= 17'(r_c0) * 17'(i_cfg.zoom);
                    r_q0    <= 17'(r_r0) * 17'(i_cfg.zoom);
                    r_p1    <= 17'(r_c1) * 17'(i_cfg.zoom);
                    r_q1    <= 17'(r_r1) * 17'(i_cfg.zoom);
                    r_hh0   <= 18'(r_h0) * 18'(i_cfg.hscale);
                    r_hh1   <= 18'(r_h1) * 18'(i_cfg.hscale);
                    r_state <= F_MUL2;
                end
                F_MUL2: begin
                    r_xm0   <= 35'(d0) * 35'($signed({1'b0, COS_F}));
                    r_xm1   <= 35'(d1) * 35'($signed({1'b0, COS_F}));
                    r_ym0   <= $signed(36'({1'b0, s0}) * 36'(SIN_F));
                    r_ym1   <= $signed(36'({1'b0, s1}) * 36'(SIN_F));
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/idl_queue.sv
`default_nettype none
module idl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire idl_pkg::t_seg i_seg,
    output logic               o_full,
    input  wire logic          i_pop,
    output idl_pkg::t_seg      o_seg,
    output logic               o_empty
);
    import idl_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_seg             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_seg   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/idl_back.sv
`default_nettype none
module idl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire idl_pkg::t_seg i_seg,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_data,
    output logic               o_last,
    output logic               o_cut
);
    import idl_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_PREP, B_DIV, B_WALK} t_bstate;
    t_bstate r_state;

    logic signed [POS_W-1:0] r_cur_x, r_cur_y, r_dx, r_dy;
    logic        [POS_W-1:0] r_m, r_rx, r_ry;
    logic        [Q_W-1:0]   r_qx, r_qy;
    logic        [IT_W-1:0]  r_it;
    logic                    r_negx, r_negy;
    logic signed [PIX_W-1:0] r_stx, r_sty;
    logic        [CNT_W-1:0] r_cnt;
    logic        [23:0]      r_color;

    logic                    r_ovalid, r_last, r_cut;
    logic        [PIX_W-1:0] r_px, r_py;
    logic        [23:0]      r_ocol;

    logic        [POS_W-1:0] ax, ay;
    logic        [POS_W:0]   tx, ty;
    logic                    bx, by;
    logic        [Q_W-1:0]   n_qx, n_qy;
    logic signed [POS_W-1:0] ndx, ndy;
    logic                    rem_now, rem_next, out_free, last, emit;

    assign ax = r_dx[POS_W-1] ? POS_W'(-r_dx) : POS_W'(r_dx);
    assign ay = r_dy[POS_W-1] ? POS_W'(-r_dy) : POS_W'(r_dy);

    assign tx   = (r_it == '0) ? {1'b0, r_rx} : {r_rx, 1'b0};
    assign ty   = (r_it == '0) ? {1'b0, r_ry} : {r_ry, 1'b0};
    assign bx   = (tx >= {1'b0, r_m});
    assign by   = (ty >= {1'b0, r_m});
    assign n_qx = {r_qx[Q_W-2:0], bx};
    assign n_qy = {r_qy[Q_W-2:0], by};

    assign ndx      = r_dx - POS_W'(r_stx);
    assign ndy      = r_dy - POS_W'(r_sty);
    assign rem_now  = far(r_dx) || far(r_dy);
    assign rem_next = far(ndx) || far(ndy);
    assign out_free = !r_ovalid || i_ready;
    assign last     = (r_cnt == CNT_W'(MAX_PIXELS - 1)) || !rem_next;
    assign emit     = (r_state == B_WALK) && rem_now && out_free;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = r_ovalid;
    assign o_data  = {4'd0, r_ocol, r_py, r_px};
    assign o_last  = r_last;
    assign o_cut   = r_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && !emit) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cur_x <= i_seg.x0;
                        r_cur_y <= i_seg.y0;
                        r_dx    <= i_seg.x1 - i_seg.x0;
                        r_dy    <= i_seg.y1 - i_seg.y0;
                        r_color <= i_seg.color;
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_m    <= (ax > ay) ? ax : ay;
                    r_rx   <= ax;
                    r_ry   <= ay;
                    r_negx <= r_dx[POS_W-1];
                    r_negy <= r_dy[POS_W-1];
                    r_qx   <= '0;
                    r_qy   <= '0;
                    r_it   <= '0;
                    r_cnt  <= '0;
                    if ((ax | ay) == '0) begin
                        r_stx   <= '0;
                        r_sty   <= '0;
                        r_state <= B_WALK;
                    end else begin
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rx <= bx ? POS_W'(tx - {1'b0, r_m}) : POS_W'(tx);
                    r_ry <= by ? POS_W'(ty - {1'b0, r_m}) : POS_W'(ty);
                    r_qx <= n_qx;
                    r_qy <= n_qy;
                    r_it <= r_it + IT_W'(1);
                    if (r_it == IT_W'(FRAC_BITS)) begin
                        r_stx   <= r_negx ? -$signed(PIX_W'(n_qx)) : $signed(PIX_W'(n_qx));
                        r_sty   <= r_negy ? -$signed(PIX_W'(n_qy)) : $signed(PIX_W'(n_qy));
                        r_state <= B_WALK;
                    end
                end
                B_WALK: begin
                    if (!rem_now) begin
                        r_state <= B_IDLE;
                    end else if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_px     <= trunc_pix(r_cur_x);
                        r_py     <= trunc_pix(r_cur_y);
                        r_ocol   <= r_color;
                        r_last   <= last;
                        r_cut    <= last && rem_next;
                        r_cur_x  <= r_cur_x + POS_W'(r_stx);
                        r_cur_y  <= r_cur_y + POS_W'(r_sty);
                        r_dx     <= ndx;
                        r_dy     <= ndy;
                        r_cnt    <= r_cnt + CNT_W'(1);
                        if (last) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/iso_project_dda_line.sv
// isometric segment rasterizer
// input stream: one item per segment, s_axis_tdata holds two grid points with
// their heights. output stream: one item per pixel, tlast on the final pixel of
// a segment, tuser set on that pixel when the walk hit the pixel limit.
// apb port: zoom, height_scale, offset_x, offset_y at 0x0, 0x4, 0x8, 0xc;
// write only while no segment is in flight.
// path: projection in the front, a queue of two segments, then a setup state
// and a restoring division for the step in the back before the first pixel.
// throughput: one pixel per cycle while the walk runs and the receiver takes it,
// up to 64 per segment; the back takes the next segment only after the walk of
// the previous one ends; the front takes a new segment only after it pushed the previous one.
// zero-length segments produce no pixels.
// reset clears the control state and restores the register defaults.
// a stalled receiver holds the output item and freezes the walk; the queue
// then fills and s_axis_tready drops.
`default_nettype none
module iso_project_dda_line (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // start_col, start_row, end_col, end_row, start_height, end_height
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    // cut_short
    output logic             m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import idl_pkg::*;

    t_cfg     r_cfg;
    t_seg     push_seg, pop_seg;
    t_reg_idx idx;
    logic     push, pop, full, empty;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zoom   <= 7'd20;
            r_cfg.hscale <= 6'sd1;
            r_cfg.offx   <= '0;
            r_cfg.offy   <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_ZOOM:   r_cfg.zoom   <= pwdata[6:0];
                REG_HSCALE: r_cfg.hscale <= $signed(pwdata[5:0]);
                REG_OFFX:   r_cfg.offx   <= pwdata[11:0];
                REG_OFFY:   r_cfg.offy   <= pwdata[11:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ZOOM:   prdata = {25'd0, r_cfg.zoom};
            REG_HSCALE: prdata = {26'd0, r_cfg.hscale};
            REG_OFFX:   prdata = {20'd0, r_cfg.offx};
            REG_OFFY:   prdata = {20'd0, r_cfg.offy};
            default:    prdata = '0;
        endcase
    end

    idl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (push),
        .o_seg   (push_seg),
        .i_full  (full)
    );

    idl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (push_seg),
        .o_full  (full),
        .i_pop   (pop),
        .o_seg   (pop_seg),
        .o_empty (empty)
    );

    idl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_seg   (pop_seg),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_cut   (m_axis_tuser)
    );

endmodule
`default_nettype wire

FILE: src/iso_project_dda_line_check.sv
`default_nettype none
`include "iso_project_dda_line_assert.svh"
module iso_project_dda_line_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser,
    input wire logic        pready
);

    // a held item keeps its payload
    `IDL_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // a cut segment is flagged on its final pixel only
    `IDL_ASSERT(a_cut_on_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)

    // nothing leaves right after reset
    `IDL_ASSERT(a_quiet_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !m_axis_tvalid)

    // register port never waits
    `IDL_ASSERT_ALWAYS(a_pready, i_clk, pready)

endmodule

bind iso_project_dda_line iso_project_dda_line_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);
`default_nettype wire

FILE: verif/tb_iso_project_dda_line.sv
`default_nettype none
module tb_iso_project_dda_line;
    import idl_pkg::*;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [23:0]        color;
        logic               last;
        logic               cut;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    iso_project_dda_line u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    t_pixel pixel_q[$];
    int     errors = 0;
    longint cycles = 0;
    int     burst_left = 0;
    int     hold_off = 0;

    logic [6:0]         zoom_r = 7'd20;
    logic signed [5:0]  hscale_r = 6'sd1;
    logic [11:0]        offx_r = '0;
    logic [11:0]        offy_r = '0;

    localparam longint ONE = 64'sd1 <<< FRAC_BITS;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall pattern plus long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (cycles[8]) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                $error("pixel with no expectation");
                errors++;
            end else begin
                e = pixel_q.pop_front();
                if (m_axis_tdata[17:0] !== e.x) begin
                    $error("pixel_x exp %0d got %0d", e.x, $signed(m_axis_tdata[17:0]));
                    errors++;
                end
                if (m_axis_tdata[35:18] !== e.y) begin
                    $error("pixel_y exp %0d got %0d", e.y, $signed(m_axis_tdata[35:18]));
                    errors++;
                end
                if (m_axis_tdata[59:36] !== e.color) begin
                    $error("pixel_color exp %h got %h", e.color, m_axis_tdata[59:36]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_pixel exp %0b got %0b", e.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== e.cut) begin
                    $error("cut_short exp %0b got %0b", e.cut, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic longint trunc_pos(longint v);
        if (v < 0) return -((-v) >>> FRAC_BITS);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint step_frac(longint a, longint m);
        longint q, r;
        q = (a >= m) ? 1 : 0;
        r = a - q * m;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= m) begin
                r = r - m;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic bit far_off(longint gx, longint cx, longint gy, longint cy);
        longint ddx, ddy;
        ddx = gx - cx;
        ddy = gy - cy;
        return (ddx >= ONE || ddx <= -ONE || ddy >= ONE || ddy <= -ONE);
    endfunction

    task automatic project_point(input longint c, input longint r, input longint h,
                                 output longint px, output longint py);
        longint p, q;
        p = c * zoom_r;
        q = r * zoom_r;
        px = (p - q) * longint'(COS_F) + longint'(offx_r) * ONE;
        py = (p + q) * longint'(SIN_F) - h * longint'(hscale_r) * ONE
             + longint'(offy_r) * ONE;
    endtask

    task automatic predict_segment(input logic [63:0] d);
        longint cx, cy, gx, gy, ax, ay, m, sx, sy;
        longint h0, h1;
        logic [23:0] color;
        int n;
        t_pixel p;
        h0 = $signed(d[50:40]);
        h1 = $signed(d[61:51]);
        project_point(d[9:0], d[19:10], h0, cx, cy);
        project_point(d[29:20], d[39:30], h1, gx, gy);
        if (h0 > 0 || h1 > 0) color = COLOR_RAISED;
        else if (h0 < 0 || h1 < 0) color = COLOR_SUNKEN;
        else color = COLOR_FLAT;
        ax = gx - cx;
        ay = gy - cy;
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        m = (ax > ay) ? ax : ay;
        sx = 0;
        sy = 0;
        if (m > 0) begin
            sx = step_frac(ax, m);
            sy = step_frac(ay, m);
            if (gx < cx) sx = -sx;
            if (gy < cy) sy = -sy;
        end
        n = 0;
        while (n < MAX_PIXELS && far_off(gx, cx, gy, cy)) begin
            p.x = trunc_pos(cx);
            p.y = trunc_pos(cy);
            p.color = color;
            p.last = 1'b0;
            p.cut = 1'b0;
            pixel_q.push_back(p);
            cx += sx;
            cy += sy;
            n++;
        end
        if (n > 0) begin
            pixel_q[$].last = 1'b1;
            pixel_q[$].cut = far_off(gx, cx, gy, cy);
        end
    endtask

    task automatic send_segment(input logic [9:0] c0, input logic [9:0] r0,
                                input logic [9:0] c1, input logic [9:0] r1,
                                input logic [10:0] h0, input logic [10:0] h1);
        logic [63:0] d;
        d = {2'b00, h1, h0, r1, c1, r0, c0};
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_segment(d);
        burst_left--;
        if (burst_left == 0) s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ZOOM:   zoom_r = v[6:0];
            REG_HSCALE: hscale_r = v[5:0];
            REG_OFFX:   offx_r = v[11:0];
            default:    offy_r = v[11:0];
        endcase
    endtask

    task automatic set_config(input logic [6:0] z, input logic [5:0] hs,
                              input logic [11:0] ox, input logic [11:0] oy);
        apb_write(REG_ZOOM, {25'd0, z});
        apb_write(REG_HSCALE, {26'd0, hs});
        apb_write(REG_OFFX, {20'd0, ox});
        apb_write(REG_OFFY, {20'd0, oy});
    endtask

    task automatic random_segment(input int span);
        logic [9:0] c0, r0, c1, r1;
        c0 = $urandom_range(0, 1023);
        r0 = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) == 0) begin
            c1 = $urandom_range(0, 1023);
            r1 = $urandom_range(0, 1023);
        end else begin
            c1 = c0 + 10'($urandom_range(0, 2 * span) - span);
            r1 = r0 + 10'($urandom_range(0, 2 * span) - span);
        end
        send_segment(c0, r0, c1, r1, 11'($urandom), 11'($urandom));
    endtask

    task automatic test_directed;
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(0, 0, 1, 0, 0, 0);
        send_segment(0, 0, 0, 1, 5, 0);
        send_segment(5, 5, 5, 5, 0, -11'sd3);
        send_segment(1023, 1023, 0, 0, 11'h3ff, 11'h400);
        send_segment(0, 1023, 1023, 0, 11'h400, 11'h400);
        send_segment(3, 7, 4, 7, 0, 0);
        send_segment(10, 10, 10, 10, 0, 11'h3ff);
        send_segment(2, 0, 0, 2, 11'h7ff, 11'h001);
        send_segment(1023, 0, 1023, 1, 0, 0);
        drain();
    endtask

    task automatic test_config_sweep;
        set_config(7'd1, 6'h10, 12'd0, 12'd0);
        repeat (20) random_segment(3);
        drain();
        set_config(7'd64, 6'h30, 12'd4095, 12'd4095);
        repeat (20) random_segment(1);
        drain();
        set_config(7'd0, 6'h0f, 12'd100, 12'd2000);
        repeat (15) random_segment(4);
        drain();
        set_config(7'd3, 6'h3f, 12'd37, 12'd0);
        repeat (15) random_segment(6);
        drain();
    endtask

    task automatic test_backpressure;
        set_config(7'd2, 6'h01, 12'd500, 12'd500);
        hold_off = 400;
        repeat (30) random_segment(5);
        drain();
    endtask

    task automatic test_random;
        for (int k = 0; k < 8; k++) begin
            set_config(7'($urandom_range(1, 64)), 6'($urandom_range(0, 32) - 16),
                       12'($urandom), 12'($urandom));
            repeat (45) random_segment($urandom_range(1, 8));
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
